>>> rtl/core/qrfd_pkg.sv
// Shared types and constants for the QR finder pattern run detector.
package qrfd_pkg;

   // Field widths
   localparam int PIXEL_W = 8;
   localparam int COORD_W = 11;
   localparam int RUN_W   = 12;
   localparam int TOL_W   = 5;

   // Configuration register map
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINARY_THRESHOLD       = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_TOLERANCE_TENTHS = 1'd1;

   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd135;
   localparam logic [TOL_W-1:0]   TOLERANCE_RESET = 5'd1;

   // Run tracking
   localparam logic [RUN_W-1:0] RUN_MAX         = 12'd4095;
   localparam int               HIST_DEPTH      = 4;
   localparam logic [2:0]       RUNS_FOR_WINDOW = 3'd4;

   // Ratio check in tenths: |10*c - 30*s| <= tol * s
   localparam logic [17:0] RATIO_SCALE         = 18'd10;
   localparam logic [17:0] CENTER_RATIO_TENTHS = 18'd30;

   // Candidate queue between run tracker and ratio checker
   localparam int QUEUE_DEPTH = 4;

   // One closed window of five runs, dark-light-dark-light-dark
   typedef struct packed {
      logic [COORD_W-1:0] col;      // column of the pixel that closed the window
      logic [COORD_W-1:0] row;
      logic [RUN_W-1:0]   side0;    // oldest dark run
      logic [RUN_W-1:0]   side1;
      logic [RUN_W-1:0]   center;
      logic [RUN_W-1:0]   side3;
      logic [RUN_W-1:0]   side4;    // newest dark run
   } cand_type;

endpackage

>>> rtl/core/qr_finder_pattern_run_detector_unit.sv
// Top level of the QR finder pattern run detector: configuration registers and the pipeline.
//
// Pixels enter in raster order on the req_ channel (req_valid / req_stall),
// one per cycle, with req_row_end on the last pixel of each row and
// req_frame_end on the last pixel of the frame. Each pixel is binarized
// against binary_threshold and each row is run-length coded. When a dark run
// closes a dark-light-dark-light-dark window of five runs whose centre is
// three times each side within ratio_tolerance_tenths, one result carrying
// the centre column, row and centre run length leaves on the rsp_ channel.
// Throughput: one pixel per cycle while req_stall is low. On its way out,
// the run tracker pushes the closed window into a 4-entry candidate queue,
// and the ratio checker reads the queue head and loads the output register.
// req_stall rises only while that queue is full, which happens only when
// the receiver holds rsp_stall for several candidates.
// Reset clears the run state, the counters, the queue and the output
// valid flag, and loads the configuration defaults (threshold 135, tolerance
// 1). Write configuration through csr_ only while the block is idle.
module qr_finder_pattern_run_detector_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   // Pixel channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [qrfd_pkg::PIXEL_W-1:0]      req_pixel_value,
   input  logic                              req_row_end,
   input  logic                              req_frame_end,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [qrfd_pkg::COORD_W-1:0]      rsp_center_x,
   output logic [qrfd_pkg::COORD_W-1:0]      rsp_center_row,
   output logic [qrfd_pkg::RUN_W-1:0]        rsp_center_run_length,
   // Configuration
   input  logic                              csr_write_enable,
   input  logic [qrfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [qrfd_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import qrfd_pkg::*;

   logic [PIXEL_W-1:0] threshold_ff;
   logic [TOL_W-1:0]   tolerance_ff;
   logic               accept;
   logic               cand_valid;
   cand_type           cand;
   cand_type           head;
   logic               q_empty;
   logic               q_full;
   logic               q_pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         tolerance_ff <= TOLERANCE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BINARY_THRESHOLD:       threshold_ff <= csr_write_data;
            CSR_RATIO_TOLERANCE_TENTHS: tolerance_ff <= csr_write_data[TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Hold pixels only while the candidate queue is full
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   qrfd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel_value (req_pixel_value),
      .row_end     (req_row_end),
      .frame_end   (req_frame_end),
      .threshold   (threshold_ff),
      .cand_valid  (cand_valid),
      .cand        (cand)
   );

   qrfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cand_valid),
      .push_data (cand),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   qrfd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head                  (head),
      .empty                 (q_empty),
      .tolerance             (tolerance_ff),
      .pop                   (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_center_x          (rsp_center_x),
      .rsp_center_row        (rsp_center_row),
      .rsp_center_run_length (rsp_center_run_length)
   );

endmodule

>>> rtl/core/qrfd_front.sv
// Front end: binarizes pixels, run-length codes each row and emits candidate windows.
module qrfd_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [qrfd_pkg::PIXEL_W-1:0]  pixel_value,
   input  logic                          row_end,
   input  logic                          frame_end,
   input  logic [qrfd_pkg::PIXEL_W-1:0]  threshold,
   output logic                          cand_valid,
   output qrfd_pkg::cand_type            cand
);
   import qrfd_pkg::*;

   localparam logic [COORD_W+1:0] WIDTH_LIMIT  = (COORD_W+2)'(MAX_WIDTH);
   localparam logic [COORD_W+1:0] HEIGHT_LIMIT = (COORD_W+2)'(MAX_HEIGHT);

   logic [RUN_W-1:0]   run_len_ff, run_len_in;
   logic               run_color_ff, run_color_in;   // 1 = light
   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [RUN_W-1:0]   hist_ff [HIST_DEPTH];
   logic [RUN_W-1:0]   hist_in [HIST_DEPTH];
   logic               oldest_dark_ff, oldest_dark_in;
   logic [2:0]         runs_cnt_ff, runs_cnt_in;

   logic               pix_bit;
   logic               close_run;
   logic [COORD_W+1:0] col_inc;
   logic [COORD_W+1:0] row_inc;

   assign pix_bit   = (pixel_value > threshold);
   assign close_run = accept && (run_len_ff != '0) && (pix_bit != run_color_ff);
   assign col_inc   = {2'b00, col_ff} + (COORD_W+2)'(1);
   assign row_inc   = {2'b00, row_ff} + (COORD_W+2)'(1);

   // Flag a window when a dark run closes behind four runs that start dark
   assign cand_valid = close_run && (runs_cnt_ff >= RUNS_FOR_WINDOW) &&
                       !run_color_ff && oldest_dark_ff;
   assign cand.col    = col_ff;
   assign cand.row    = row_ff;
   assign cand.side0  = hist_ff[0];
   assign cand.side1  = hist_ff[1];
   assign cand.center = hist_ff[2];
   assign cand.side3  = hist_ff[3];
   assign cand.side4  = run_len_ff;

   // Track the open run, the closed-run history and the pixel position
   always_comb begin
      run_len_in     = run_len_ff;
      run_color_in   = run_color_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      oldest_dark_in = oldest_dark_ff;
      runs_cnt_in    = runs_cnt_ff;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end

      if (accept) begin
         if (run_len_ff == '0) begin
            run_len_in   = RUN_W'(1);
            run_color_in = pix_bit;
         end else if (pix_bit == run_color_ff) begin
            if (run_len_ff < RUN_MAX) begin
               run_len_in = run_len_ff + RUN_W'(1);
            end
         end else begin
            // Shift the closed run into the history; runs alternate in color
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
               hist_in[i] = hist_ff[i+1];
            end
            hist_in[HIST_DEPTH-1] = run_len_ff;
            oldest_dark_in        = run_color_ff;
            if (runs_cnt_ff < RUNS_FOR_WINDOW) begin
               runs_cnt_in = runs_cnt_ff + 3'd1;
            end
            run_len_in   = RUN_W'(1);
            run_color_in = pix_bit;
         end

         if (col_inc == WIDTH_LIMIT) begin
            col_in = '0;
         end else begin
            col_in = col_inc[COORD_W-1:0];
         end

         // Drop the open run and the row history at row end or frame end
         if (row_end || frame_end) begin
            run_len_in  = '0;
            runs_cnt_in = '0;
            col_in      = '0;
            if (frame_end) begin
               row_in = '0;
            end else if (row_inc == HEIGHT_LIMIT) begin
               row_in = '0;
            end else begin
               row_in = row_inc[COORD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff     <= '0;
         run_color_ff   <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
         oldest_dark_ff <= 1'b0;
         runs_cnt_ff    <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         run_len_ff     <= run_len_in;
         run_color_ff   <= run_color_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         oldest_dark_ff <= oldest_dark_in;
         runs_cnt_ff    <= runs_cnt_in;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

endmodule

>>> rtl/core/qrfd_queue.sv
// Candidate queue: short FIFO between the run tracker and the ratio checker.
module qrfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qrfd_pkg::cand_type push_data,
   input  logic               pop,
   output qrfd_pkg::cand_type head,
   output logic               empty,
   output logic               full
);
   import qrfd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cand_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry at the tail
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/qrfd_back.sv
// Back end: checks the 1:1:3:1:1 ratio of a candidate and holds the result register.
module qrfd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  qrfd_pkg::cand_type            head,
   input  logic                          empty,
   input  logic [qrfd_pkg::TOL_W-1:0]    tolerance,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [qrfd_pkg::COORD_W-1:0]  rsp_center_x,
   output logic [qrfd_pkg::COORD_W-1:0]  rsp_center_row,
   output logic [qrfd_pkg::RUN_W-1:0]    rsp_center_run_length
);
   import qrfd_pkg::*;

   // |10*c - 30*s| <= tol * s, all in 18 bits
   function automatic logic side_ok(input logic [RUN_W-1:0] c, input logic [RUN_W-1:0] s,
                                    input logic [TOL_W-1:0] tol);
      logic [17:0] a;
      logic [17:0] b;
      logic [17:0] diff;
      logic [17:0] lim;
      a    = 18'(c) * RATIO_SCALE;
      b    = 18'(s) * CENTER_RATIO_TENTHS;
      diff = (a > b) ? (a - b) : (b - a);
      lim  = 18'(tol) * 18'(s);
      return diff <= lim;
   endfunction

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] center_x_ff, center_x_in;
   logic [COORD_W-1:0] center_row_ff;
   logic [RUN_W-1:0]   center_len_ff;
   logic               out_free;
   logic               hit;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !empty && out_free;

   assign hit = side_ok(head.center, head.side0, tolerance) &&
                side_ok(head.center, head.side1, tolerance) &&
                side_ok(head.center, head.side3, tolerance) &&
                side_ok(head.center, head.side4, tolerance);

   // Middle of the centre run, modulo the coordinate width
   assign center_x_in = head.col - head.side4[COORD_W-1:0] - head.side3[COORD_W-1:0]
                        - head.center[COORD_W-1:0] + head.center[RUN_W-1:1];

   // Load the result register when it is free; clear it after a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = pop && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && hit) begin
         center_x_ff   <= center_x_in;
         center_row_ff <= head.row;
         center_len_ff <= head.center;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_center_x          = center_x_ff;
   assign rsp_center_row        = center_row_ff;
   assign rsp_center_run_length = center_len_ff;

endmodule

>>> verif/tb_top.sv
// Testbench for the QR finder pattern run detector: pixel driver, result monitor and predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import qrfd_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic               row_end;
      logic               frame_end;
   } pixel_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] row;
      logic [RUN_W-1:0]   len;
   } finder_hit_type;

   typedef enum {ROW_OPEN, ROW_CLOSE, FRAME_CLOSE} row_stop_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel_value = '0;
   logic                   req_row_end = 1'b0;
   logic                   req_frame_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COORD_W-1:0]     rsp_center_x;
   logic [COORD_W-1:0]     rsp_center_row;
   logic [RUN_W-1:0]       rsp_center_run_length;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BINARY_THRESHOLD;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Stimulus and scoreboard
   pixel_item_type pixel_q[$];
   finder_hit_type finder_q[$];
   pixel_item_type next_pix;
   finder_hit_type want;
   logic        pix_taken = 1'b0;
   int          pixels_sent = 0;
   int          pixels_taken = 0;
   int          errors = 0;
   int          stalled_cycles = 0;
   int          snd_idle_pct = 0;
   int          rcv_idle_pct = 0;

   // Predictor state and its copy of the registers
   logic [PIXEL_W-1:0] thr_r = THRESHOLD_RESET;
   logic [TOL_W-1:0]   tol_r = TOLERANCE_RESET;
   logic [RUN_W-1:0]   open_len = '0;
   logic               open_light = 1'b0;
   logic [COORD_W-1:0] col_pos = '0;
   logic [COORD_W-1:0] row_pos = '0;
   logic [RUN_W-1:0]   past_len[HIST_DEPTH] = '{default: '0};
   logic               first_dark = 1'b0;
   logic [2:0]         closed_cnt = '0;

   qr_finder_pattern_run_detector_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_pixel_value       (req_pixel_value),
      .req_row_end           (req_row_end),
      .req_frame_end         (req_frame_end),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_center_x          (rsp_center_x),
      .rsp_center_row        (rsp_center_row),
      .rsp_center_run_length (rsp_center_run_length),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #2 clock = ~clock;

   // Centre-to-side check in tenths, cross-multiplied
   function automatic logic within_ratio(logic [RUN_W-1:0] mid, logic [RUN_W-1:0] side);
      int unsigned scaled_mid;
      int unsigned scaled_side;
      int unsigned gap;
      int unsigned allowed;
      scaled_mid  = 32'(RATIO_SCALE) * 32'(mid);
      scaled_side = 32'(CENTER_RATIO_TENTHS) * 32'(side);
      gap = (scaled_mid > scaled_side) ? scaled_mid - scaled_side : scaled_side - scaled_mid;
      allowed = 32'(tol_r) * 32'(side);
      return gap <= allowed;
   endfunction

   // Close the open run, test the five-run window, shift the history
   function automatic void retire_run();
      logic             dark;
      logic [RUN_W-1:0] mid;
      int unsigned      origin;
      finder_hit_type   hit;
      dark = !open_light;
      mid  = past_len[2];
      if (closed_cnt >= RUNS_FOR_WINDOW && dark && first_dark &&
          within_ratio(mid, past_len[0]) && within_ratio(mid, past_len[1]) &&
          within_ratio(mid, past_len[3]) && within_ratio(mid, open_len)) begin
         origin  = 32'(col_pos) - 32'(open_len) - 32'(past_len[3]) - 32'(mid);
         hit.x   = COORD_W'(origin + 32'(mid) / 2);
         hit.row = row_pos;
         hit.len = mid;
         finder_q.insert(finder_q.size(), hit);
      end
      past_len[0] = past_len[1];
      past_len[1] = past_len[2];
      past_len[2] = past_len[3];
      past_len[3] = open_len;
      first_dark  = !dark;
      if (closed_cnt < RUNS_FOR_WINDOW) closed_cnt++;
   endfunction

   // Advance the run coder by one accepted pixel
   function automatic void track_pixel(logic [PIXEL_W-1:0] value, logic row_end,
                                       logic frame_end);
      logic light;
      light = value > thr_r;
      if (open_len == '0) begin
         open_len   = RUN_W'(1);
         open_light = light;
      end else if (light == open_light) begin
         if (open_len != RUN_MAX) open_len++;
      end else begin
         retire_run();
         open_len   = RUN_W'(1);
         open_light = light;
      end
      col_pos++;
      if (row_end || frame_end) begin
         open_len   = '0;
         closed_cnt = '0;
         col_pos    = '0;
         row_pos    = frame_end ? '0 : row_pos + 1'b1;
      end
   endfunction

   // Stimulus builders
   function automatic void push_pixel(logic [PIXEL_W-1:0] value, logic row_end,
                                      logic frame_end);
      pixel_item_type item;
      item.value     = value;
      item.row_end   = row_end;
      item.frame_end = frame_end;
      pixel_q.insert(pixel_q.size(), item);
      pixels_sent++;
   endfunction

   function automatic logic [PIXEL_W-1:0] shade(logic dark);
      if (dark || thr_r == 8'hFF) return PIXEL_W'($urandom_range(int'(thr_r), 0));
      return PIXEL_W'($urandom_range(255, int'(thr_r) + 1));
   endfunction

   function automatic void push_run(logic dark, int len);
      for (int i = 0; i < len; i++) push_pixel(shade(dark), 1'b0, 1'b0);
   endfunction

   function automatic void mark_row_stop(row_stop_type stop);
      pixel_item_type last;
      last = pixel_q.pop_back();
      if (stop == ROW_CLOSE) last.row_end = 1'b1;
      else if (stop == FRAME_CLOSE) last.frame_end = 1'b1;
      pixel_q.insert(pixel_q.size(), last);
   endfunction

   function automatic row_stop_type random_stop();
      int pick;
      pick = $urandom_range(19);
      if (pick < 15) return ROW_CLOSE;
      if (pick < 17) return FRAME_CLOSE;
      return ROW_OPEN;
   endfunction

   // Light lead, dark-light-dark-light-dark, light tail; jittered unless clean
   function automatic void add_finder_row(logic clean);
      int unit;
      int mid;
      int side[4];
      unit = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
      mid  = 3 * unit;
      for (int i = 0; i < 4; i++) begin
         side[i] = unit;
         if (!clean && $urandom_range(3) == 0) side[i] = unit - 1 + $urandom_range(2);
         if (side[i] < 1) side[i] = 1;
      end
      if (!clean && $urandom_range(3) == 0) mid = mid - 1 + $urandom_range(2);
      if (!clean && $urandom_range(4) == 0) begin
         push_run(1'b1, $urandom_range(3, 1));
         push_run(1'b0, $urandom_range(3, 1));
      end
      push_run(1'b0, $urandom_range(3));
      push_run(1'b1, side[0]);
      push_run(1'b0, side[1]);
      push_run(1'b1, mid);
      push_run(1'b0, side[2]);
      push_run(1'b1, side[3]);
      push_run(1'b0, $urandom_range(3, 1));
      mark_row_stop(clean ? ROW_CLOSE : random_stop());
   endfunction

   // Mostly finder rows, mixed with noise rows and loose pixels
   function automatic void fill_random(int count);
      int target;
      int pick;
      target = pixels_sent + count;
      while (pixels_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            add_finder_row(1'b0);
         end else if (pick < 80) begin
            repeat ($urandom_range(40, 1)) push_pixel(PIXEL_W'($urandom_range(255)), 1'b0, 1'b0);
            mark_row_stop(random_stop());
         end else begin
            push_pixel(PIXEL_W'($urandom_range(255)), $urandom_range(7) == 0,
                       $urandom_range(15) == 0);
         end
      end
   endfunction

   task automatic set_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      if (index == CSR_BINARY_THRESHOLD) thr_r = data;
      else tol_r = data[TOL_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(logic [PIXEL_W-1:0] thr, logic [TOL_W-1:0] tol);
      set_reg(CSR_BINARY_THRESHOLD, thr);
      set_reg(CSR_RATIO_TOLERANCE_TENTHS, CSR_DATA_W'(tol));
   endtask

   // Wait for every pixel and every expected result, then let the pipe empty
   task automatic settle();
      while (pixels_taken != pixels_sent || finder_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Driver: advance to the next pixel once the current transfer completes
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || pix_taken) begin
         if (pixel_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            next_pix = pixel_q.pop_front();
            req_valid       <= 1'b1;
            req_pixel_value <= next_pix.value;
            req_row_end     <= next_pix.row_end;
            req_frame_end   <= next_pix.frame_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on pixel transfers, check result transfers, watch for hangs
   always @(posedge clock) begin
      pix_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pix_taken = 1'b1;
            pixels_taken++;
            track_pixel(req_pixel_value, req_row_end, req_frame_end);
         end
         if (rsp_valid && !rsp_stall) begin
            if (finder_q.size() == 0) begin
               $display("%0t unexpected result: center_x %0d center_row %0d length %0d",
                        $time, rsp_center_x, rsp_center_row, rsp_center_run_length);
               errors++;
            end else begin
               want = finder_q.pop_front();
               if (rsp_center_x !== want.x) begin
                  $display("%0t center_x: expected %0d, actual %0d",
                           $time, want.x, rsp_center_x);
                  errors++;
               end
               if (rsp_center_row !== want.row) begin
                  $display("%0t center_row: expected %0d, actual %0d",
                           $time, want.row, rsp_center_row);
                  errors++;
               end
               if (rsp_center_run_length !== want.len) begin
                  $display("%0t center_run_length: expected %0d, actual %0d",
                           $time, want.len, rsp_center_run_length);
                  errors++;
               end
            end
         end
         if (pix_taken || (rsp_valid && !rsp_stall) ||
             (pixel_q.size() == 0 && !req_valid && finder_q.size() == 0)) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
               $display("%0t no transfer for %0d cycles", $time, stalled_cycles);
               $display("[qr_finder_pattern_run_detector_unit] ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows at the reset settings
      snd_idle_pct = 8;
      rcv_idle_pct = 66;
      @(posedge clock);
      // 1:1:3:1:1 closed by the row-end pixel, threshold edges 135 and 136
      push_pixel(8'd135, 1'b0, 1'b0);
      push_pixel(8'd136, 1'b0, 1'b0);
      push_pixel(8'd0, 1'b0, 1'b0);
      push_pixel(8'd0, 1'b0, 1'b0);
      push_pixel(8'd0, 1'b0, 1'b0);
      push_pixel(8'd255, 1'b0, 1'b0);
      push_pixel(8'd135, 1'b0, 1'b0);
      push_pixel(8'd136, 1'b1, 1'b0);
      // Even centre length, window closed by the frame-end pixel
      push_pixel(8'd255, 1'b0, 1'b0);
      push_run(1'b1, 2);
      push_run(1'b0, 2);
      push_run(1'b1, 6);
      push_run(1'b0, 2);
      push_run(1'b1, 2);
      push_pixel(8'd200, 1'b0, 1'b1);
      // Row end and frame end together on a one-pixel row
      push_pixel(8'd0, 1'b1, 1'b1);
      settle();

      configure(8'd90, 5'd0);
      @(posedge clock);
      fill_random(350);
      settle();

      configure(8'd0, 5'd31);
      @(posedge clock);
      fill_random(350);
      settle();

      snd_idle_pct = 66;
      rcv_idle_pct = 8;
      configure(8'd255, 5'd12);
      @(posedge clock);
      fill_random(150);
      settle();

      configure(8'd170, 5'd30);
      @(posedge clock);
      fill_random(350);
      settle();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      configure(8'd60, 5'd5);
      @(posedge clock);
      fill_random(300);
      fill_random(350);
      settle();

      if (errors == 0) begin
         $display("[qr_finder_pattern_run_detector_unit] OK");
      end else begin
         $display("[qr_finder_pattern_run_detector_unit] ERROR");
      end
      $finish;
   end

endmodule
